// File: rtl/core/damped_spring_chaser_defines.svh
// Assertion macros shared by the damped spring chaser RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef DAMPED_SPRING_CHASER_DEFINES_SVH
`define DAMPED_SPRING_CHASER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DSC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dsc assertion failed");

// Next-cycle implication, disabled during reset.
`define DSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dsc assertion failed");

`endif

// File: rtl/core/dsc_pkg.sv
// Shared types, codes and fixed-point helpers of the damped spring chaser.
// No dependencies; imported by dsc_ctrl, dsc_datapath and the top level.
package dsc_pkg;

   localparam logic [2:0] CSR_FRICTION  = 3'd0;
   localparam logic [2:0] CSR_GAIN      = 3'd1;
   localparam logic [2:0] CSR_TSCALE    = 3'd2;
   localparam logic [2:0] CSR_THRESHOLD = 3'd3;
   localparam logic [2:0] CSR_SETTLE    = 3'd4;

   localparam logic [15:0] FRICTION_RST  = 16'd52429;
   localparam logic [15:0] GAIN_RST      = 16'd6554;
   localparam logic [7:0]  TSCALE_RST    = 8'd30;
   localparam logic [15:0] THRESHOLD_RST = 16'd78;
   localparam logic [21:0] SETTLE_RST    = 22'd32768;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_WAKE, OP_TGT, OP_DIST, OP_STILL, OP_SNAP, OP_TSCALE,
      OP_POW_R, OP_POW_B, OP_SQ_INIT, OP_SQ_STEP, OP_POW_F, OP_GAIN,
      OP_VX_DAMP, OP_VX_PULL, OP_VX_ADD, OP_VY_DAMP, OP_VY_PULL, OP_VY_ADD,
      OP_POS, OP_DIR
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_REST, ST_TGT, ST_DIST, ST_STILL, ST_SNAP, ST_TSCALE,
      ST_POW_R, ST_POW_B, ST_SQ_INIT, ST_SQ_STEP, ST_POW_F, ST_GAIN,
      ST_VX_DAMP, ST_VX_PULL, ST_VX_ADD, ST_VY_DAMP, ST_VY_PULL, ST_VY_ADD,
      ST_POS, ST_DIR
   } state_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] idx;
   } cmd_type;

   typedef struct packed {
      logic settled;
      logic dt_zero;
   } stat_type;

   function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
      if (s > 33'sd2147483647)       return 32'sh7fff_ffff;
      else if (s < -33'sd2147483648) return 32'sh8000_0000;
      else                           return s[31:0];
   endfunction

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      return sat33({a[31], a} + {b[31], b});
   endfunction

   function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      return sat33({a[31], a} - {b[31], b});
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] a);
      return a[31] ? (~a + 32'd1) : a;
   endfunction

   // Scale a magnitude product back to Q16.16, clamp, and restore the sign.
   function automatic logic signed [31:0] mul_fix(input logic neg, input logic [63:0] prod);
      logic [47:0] p;
      p = prod[63:16];
      if (p >= 48'h0000_8000_0000) return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
      else                         return neg ? -p[31:0] : p[31:0];
   endfunction

endpackage

// File: rtl/core/dsc_datapath.sv
// Datapath of the damped spring chaser: state registers, one shared multiplier,
// a four-bit-per-cycle square root step and the result registers. Uses dsc_pkg.
module dsc_datapath import dsc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [21:0]        csr_wdata,
   input  logic [31:0]        req_time_now,
   input  logic signed [31:0] req_scroll_x,
   input  logic signed [31:0] req_scroll_y,
   input  logic signed [31:0] req_overshoot_x,
   input  logic signed [31:0] req_overshoot_y,
   input  logic [31:0]        req_cycle_id,
   output logic signed [31:0] rsp_dir_x,
   output logic signed [31:0] rsp_dir_y,
   output logic               rsp_dir_valid,
   output logic               rsp_is_stable,
   output logic               rsp_became_stable
);

   logic [15:0] friction_ff, gain_ff, thr_ff;
   logic [7:0]  tscale_ff;
   logic [21:0] settle_ff;

   logic signed [31:0] cx_ff, cy_ff, vx_ff, vy_ff;
   logic [31:0]        last_ff, timer_ff, seen_ff;
   logic               settled_ff, became_ff, dt_zero_ff;

   logic [31:0]        now_ff, cyc_ff, dt_ff, t_ff, g_ff;
   logic signed [31:0] sx_ff, sy_ff, ox_ff, oy_ff, tx_ff, ty_ff, dx_ff, dy_ff;
   logic signed [31:0] ta_ff, tb_ff;
   logic [16:0]        r_ff;
   logic [15:0]        base_ff, root_ff, sq_res_ff;
   logic [18:0]        sq_rem_ff;
   logic [31:0]        sq_x_ff;

   logic signed [31:0] dir_x_ff, dir_y_ff;
   logic               dir_valid_ff, is_stable_ff, became_out_ff;

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [15:0] sq_res_in;
   logic [18:0] sq_rem_in;
   logic [32:0] timer_sum;
   logic [31:0] timer_sat;
   logic        still;

   assign prod = mul_a * mul_b;

   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      case (cmd.op)
         OP_TSCALE: begin mul_a = dt_ff;                mul_b = {24'd0, tscale_ff}; end
         OP_POW_R:  begin mul_a = {15'd0, r_ff};        mul_b = {16'd0, base_ff}; end
         OP_POW_B:  begin mul_a = {16'd0, base_ff};     mul_b = {16'd0, base_ff}; end
         OP_POW_F:  begin mul_a = {15'd0, r_ff};        mul_b = {16'd0, sq_res_ff}; end
         OP_GAIN:   begin mul_a = t_ff;                 mul_b = {16'd0, gain_ff}; end
         OP_VX_DAMP: begin mul_a = mag32(vx_ff);        mul_b = {15'd0, r_ff}; end
         OP_VX_PULL: begin mul_a = mag32(dx_ff);        mul_b = g_ff; end
         OP_VY_DAMP: begin mul_a = mag32(vy_ff);        mul_b = {15'd0, r_ff}; end
         OP_VY_PULL: begin mul_a = mag32(dy_ff);        mul_b = g_ff; end
         default: ;
      endcase
   end

   // Four result bits of the digit-by-digit square root per cycle.
   always_comb begin
      logic [15:0] res;
      logic [18:0] rem;
      logic [18:0] trial;
      res = sq_res_ff;
      rem = sq_rem_ff;
      for (int i = 0; i < 4; i++) begin
         rem   = {rem[16:0], sq_x_ff[31 - 2*i -: 2]};
         trial = {1'b0, res, 2'b01};
         if (rem >= trial) begin
            rem = rem - trial;
            res = {res[14:0], 1'b1};
         end else begin
            res = {res[14:0], 1'b0};
         end
      end
      sq_res_in = res;
      sq_rem_in = rem;
   end

   assign still     = (mag32(dx_ff) < {16'd0, thr_ff}) && (mag32(vx_ff) < {16'd0, thr_ff});
   assign timer_sum = {1'b0, timer_ff} + {1'b0, dt_ff};
   assign timer_sat = timer_sum[32] ? 32'hffff_ffff : timer_sum[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         friction_ff <= FRICTION_RST;
         gain_ff     <= GAIN_RST;
         tscale_ff   <= TSCALE_RST;
         thr_ff      <= THRESHOLD_RST;
         settle_ff   <= SETTLE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRICTION:  friction_ff <= csr_wdata[15:0];
            CSR_GAIN:      gain_ff     <= csr_wdata[15:0];
            CSR_TSCALE:    tscale_ff   <= csr_wdata[7:0];
            CSR_THRESHOLD: thr_ff      <= csr_wdata[15:0];
            CSR_SETTLE:    settle_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff      <= '0;
         cy_ff      <= '0;
         vx_ff      <= '0;
         vy_ff      <= '0;
         last_ff    <= '0;
         timer_ff   <= '0;
         seen_ff    <= '0;
         settled_ff <= 1'b1;
         became_ff  <= 1'b0;
         dt_zero_ff <= 1'b0;
      end else begin
         case (cmd.op)
            OP_WAKE: if (cyc_ff != seen_ff) settled_ff <= 1'b0;
            OP_TGT:  became_ff <= 1'b0;
            OP_DIST: begin
               last_ff    <= now_ff;
               dt_zero_ff <= !(now_ff > last_ff);
            end
            OP_STILL: begin
               if (still) begin
                  if (timer_sat > {10'd0, settle_ff}) begin
                     timer_ff   <= '0;
                     settled_ff <= 1'b1;
                     seen_ff    <= cyc_ff;
                     became_ff  <= 1'b1;
                  end else begin
                     timer_ff <= timer_sat;
                  end
               end else begin
                  timer_ff <= '0;
               end
            end
            OP_SNAP: begin
               cx_ff <= tx_ff;
               cy_ff <= ty_ff;
            end
            OP_VX_ADD: vx_ff <= sat_add(ta_ff, tb_ff);
            OP_VY_ADD: vy_ff <= sat_add(ta_ff, tb_ff);
            OP_POS: begin
               cx_ff <= sat_add(cx_ff, vx_ff);
               cy_ff <= sat_add(cy_ff, vy_ff);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            now_ff <= req_time_now;
            sx_ff  <= req_scroll_x;
            sy_ff  <= req_scroll_y;
            ox_ff  <= req_overshoot_x;
            oy_ff  <= req_overshoot_y;
            cyc_ff <= req_cycle_id;
         end
         OP_WAKE: begin
            dir_x_ff      <= '0;
            dir_y_ff      <= '0;
            dir_valid_ff  <= 1'b0;
            is_stable_ff  <= (cyc_ff == seen_ff);
            became_out_ff <= 1'b0;
         end
         OP_TGT: begin
            tx_ff <= sat_sub(sx_ff, ox_ff);
            ty_ff <= sat_sub(sy_ff, oy_ff);
         end
         OP_DIST: begin
            dt_ff <= (now_ff > last_ff) ? now_ff - last_ff : 32'd0;
            dx_ff <= sat_sub(tx_ff, cx_ff);
            dy_ff <= sat_sub(ty_ff, cy_ff);
         end
         OP_TSCALE: begin
            t_ff    <= (prod[63:32] != 32'd0) ? 32'hffff_ffff : prod[31:0];
            r_ff    <= 17'h10000;
            base_ff <= friction_ff;
            root_ff <= friction_ff;
         end
         OP_POW_R: if (t_ff[16 + cmd.idx]) r_ff <= prod[32:16];
         OP_POW_B: base_ff <= prod[31:16];
         OP_SQ_INIT: begin
            sq_x_ff   <= {root_ff, 16'd0};
            sq_res_ff <= '0;
            sq_rem_ff <= '0;
         end
         OP_SQ_STEP: begin
            sq_x_ff   <= {sq_x_ff[23:0], 8'd0};
            sq_res_ff <= sq_res_in;
            sq_rem_ff <= sq_rem_in;
         end
         OP_POW_F: begin
            root_ff <= sq_res_ff;
            if (t_ff[4'd15 - cmd.idx]) r_ff <= prod[32:16];
         end
         OP_GAIN:    g_ff  <= prod[47:16];
         OP_VX_DAMP: ta_ff <= mul_fix(vx_ff[31], prod);
         OP_VX_PULL: tb_ff <= mul_fix(dx_ff[31], prod);
         OP_VY_DAMP: ta_ff <= mul_fix(vy_ff[31], prod);
         OP_VY_PULL: tb_ff <= mul_fix(dy_ff[31], prod);
         OP_DIR: begin
            dir_x_ff      <= sat_sub(tx_ff, cx_ff);
            dir_y_ff      <= sat_sub(ty_ff, cy_ff);
            dir_valid_ff  <= 1'b1;
            is_stable_ff  <= settled_ff;
            became_out_ff <= became_ff;
         end
         default: ;
      endcase
   end

   assign stat.settled = settled_ff;
   assign stat.dt_zero = dt_zero_ff;

   assign rsp_dir_x         = dir_x_ff;
   assign rsp_dir_y         = dir_y_ff;
   assign rsp_dir_valid     = dir_valid_ff;
   assign rsp_is_stable     = is_stable_ff;
   assign rsp_became_stable = became_out_ff;

endmodule

// File: rtl/core/dsc_ctrl.sv
// Controller of the damped spring chaser: sequences the datapath operations
// and owns the handshakes. Uses dsc_pkg and damped_spring_chaser_defines.svh.
`include "damped_spring_chaser_defines.svh"
module dsc_ctrl import dsc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type  state_ff, state_in;
   logic [3:0] idx_ff, idx_in;
   logic [1:0] sub_ff, sub_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free, fire;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         sub_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         sub_ff       <= sub_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      sub_in    = sub_ff;
      cmd.op    = OP_NONE;
      cmd.idx   = idx_ff;
      req_ready = 1'b0;
      fire      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = stat.settled ? ST_REST : ST_TGT;
            end
         end
         ST_REST: begin
            // hold until the result slot frees up
            if (slot_free) begin
               cmd.op   = OP_WAKE;
               fire     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_TGT: begin
            cmd.op   = OP_TGT;
            state_in = ST_DIST;
         end
         ST_DIST: begin
            cmd.op   = OP_DIST;
            state_in = ST_STILL;
         end
         ST_STILL: begin
            // time not advancing: nothing moves
            if (stat.dt_zero) begin
               state_in = ST_DIR;
            end else begin
               cmd.op   = OP_STILL;
               state_in = ST_SNAP;
            end
         end
         ST_SNAP: begin
            if (stat.settled) begin
               cmd.op   = OP_SNAP;
               state_in = ST_DIR;
            end else begin
               state_in = ST_TSCALE;
            end
         end
         ST_TSCALE: begin
            cmd.op   = OP_TSCALE;
            idx_in   = '0;
            state_in = ST_POW_R;
         end
         ST_POW_R: begin
            cmd.op   = OP_POW_R;
            state_in = ST_POW_B;
         end
         ST_POW_B: begin
            cmd.op = OP_POW_B;
            idx_in = idx_ff + 4'd1;
            state_in = (idx_ff == 4'd15) ? ST_SQ_INIT : ST_POW_R;
         end
         ST_SQ_INIT: begin
            cmd.op   = OP_SQ_INIT;
            sub_in   = '0;
            state_in = ST_SQ_STEP;
         end
         ST_SQ_STEP: begin
            cmd.op   = OP_SQ_STEP;
            sub_in   = sub_ff + 2'd1;
            if (sub_ff == 2'd3) state_in = ST_POW_F;
         end
         ST_POW_F: begin
            cmd.op   = OP_POW_F;
            idx_in   = idx_ff + 4'd1;
            state_in = (idx_ff == 4'd15) ? ST_GAIN : ST_SQ_INIT;
         end
         ST_GAIN: begin
            cmd.op   = OP_GAIN;
            state_in = ST_VX_DAMP;
         end
         ST_VX_DAMP: begin cmd.op = OP_VX_DAMP; state_in = ST_VX_PULL; end
         ST_VX_PULL: begin cmd.op = OP_VX_PULL; state_in = ST_VX_ADD;  end
         ST_VX_ADD:  begin cmd.op = OP_VX_ADD;  state_in = ST_VY_DAMP; end
         ST_VY_DAMP: begin cmd.op = OP_VY_DAMP; state_in = ST_VY_PULL; end
         ST_VY_PULL: begin cmd.op = OP_VY_PULL; state_in = ST_VY_ADD;  end
         ST_VY_ADD:  begin cmd.op = OP_VY_ADD;  state_in = ST_POS;     end
         ST_POS: begin
            cmd.op   = OP_POS;
            state_in = ST_DIR;
         end
         ST_DIR: begin
            if (slot_free) begin
               cmd.op   = OP_DIR;
               fire     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || fire;
   end

   assign rsp_valid = rsp_valid_ff;

   `DSC_ASSERT_NEXT(a_fire_shows, clock, reset, fire, rsp_valid && state_ff == ST_IDLE)
   `DSC_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
   `DSC_ASSERT_NOW(a_root_done, clock, reset, state_ff == ST_POW_F, $past(state_ff) == ST_SQ_STEP)

endmodule

// File: rtl/core/damped_spring_chaser.sv
// Top level of the damped spring chaser: ties the controller to the datapath.
// Uses dsc_pkg, dsc_ctrl and dsc_datapath.
//
// One item is worked at a time. An item that finds the chaser at rest goes
// from the accepting state through the wake state to its result. One whose
// time stamp does not advance skips the motion, and one that settles snaps
// to its target. A full wobble step is paced by the single shared 32x32
// multiplier walking the friction power: two products per integer bit, then
// per fraction bit a square root of four bits per cycle and one product.
// The four velocity products and their two sums follow. A result waits in
// its final state while a previous result still waits in the output
// register. The input side is ready again as soon as a result enters the
// output register, even while that result still waits to be taken.
module damped_spring_chaser import dsc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [21:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_time_now,
   input  logic signed [31:0] req_scroll_x,
   input  logic signed [31:0] req_scroll_y,
   input  logic signed [31:0] req_overshoot_x,
   input  logic signed [31:0] req_overshoot_y,
   input  logic [31:0]        req_cycle_id,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_dir_x,
   output logic signed [31:0] rsp_dir_y,
   output logic               rsp_dir_valid,
   output logic               rsp_is_stable,
   output logic               rsp_became_stable
);

   cmd_type  cmd;
   stat_type stat;

   dsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dsc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_time_now      (req_time_now),
      .req_scroll_x      (req_scroll_x),
      .req_scroll_y      (req_scroll_y),
      .req_overshoot_x   (req_overshoot_x),
      .req_overshoot_y   (req_overshoot_y),
      .req_cycle_id      (req_cycle_id),
      .rsp_dir_x         (rsp_dir_x),
      .rsp_dir_y         (rsp_dir_y),
      .rsp_dir_valid     (rsp_dir_valid),
      .rsp_is_stable     (rsp_is_stable),
      .rsp_became_stable (rsp_became_stable)
   );

endmodule

// File: tb/tb_damped_spring_chaser.sv
// Testbench for the damped spring chaser: drives steps, predicts each result and compares.
// Depends on dsc_pkg and the damped_spring_chaser RTL.
module tb_damped_spring_chaser import dsc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CSR_UNUSED = 3'd7;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [21:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [31:0]        req_time_now = '0;
   logic signed [31:0] req_scroll_x = '0;
   logic signed [31:0] req_scroll_y = '0;
   logic signed [31:0] req_overshoot_x = '0;
   logic signed [31:0] req_overshoot_y = '0;
   logic [31:0]        req_cycle_id = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_dir_x, rsp_dir_y;
   logic               rsp_dir_valid, rsp_is_stable, rsp_became_stable;

   damped_spring_chaser DUT (.*);

   always #6 clock = ~clock;

   typedef struct packed {
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic               dir_valid;
      logic               is_stable;
      logic               became_stable;
   } step_result_type;

   step_result_type expected_q[$];
   int   error_count = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   longint cycle_count = 0;

   // predictor copy of the registers and state
   logic [15:0] m_friction, m_gain, m_threshold;
   logic [7:0]  m_tscale;
   logic [21:0] m_settle;
   longint      m_pos_x, m_pos_y, m_vel_x, m_vel_y;
   logic [31:0] m_last_time, m_still_timer, m_seen_cycle;
   logic        m_settled;
   logic [31:0] clock_now;
   logic [31:0] cur_cycle;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint abs64(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint scale_signed(longint a, logic [31:0] b);
      logic [63:0] p;
      p = (64'(abs64(a)) * 64'(b)) >> 16;
      if (p > 64'h8000_0000) p = 64'h8000_0000;
      return clamp32((a < 0) ? -longint'(p) : longint'(p));
   endfunction

   function automatic logic [31:0] int_sqrt(logic [31:0] x);
      logic [31:0] res, bitv;
      res = 0;
      bitv = 32'h4000_0000;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [31:0] friction_power(logic [31:0] f, logic [31:0] t);
      logic [63:0] r, base, root;
      r = 64'd65536;
      base = f;
      root = f;
      for (int i = 0; i < 16; i++) begin
         if (t[16 + i]) r = (r * base) >> 16;
         base = (base * base) >> 16;
      end
      for (int i = 1; i <= 16; i++) begin
         root = int_sqrt(32'(root << 16));
         if (t[16 - i]) r = (r * root) >> 16;
      end
      return r[31:0];
   endfunction

   task automatic reset_predictor();
      m_friction = FRICTION_RST;
      m_gain = GAIN_RST;
      m_tscale = TSCALE_RST;
      m_threshold = THRESHOLD_RST;
      m_settle = SETTLE_RST;
      m_pos_x = 0; m_pos_y = 0; m_vel_x = 0; m_vel_y = 0;
      m_last_time = 0; m_still_timer = 0; m_seen_cycle = 0;
      m_settled = 1'b1;
   endtask

   task automatic predict_step(logic [31:0] now, logic signed [31:0] sx, logic signed [31:0] sy,
                               logic signed [31:0] ox, logic signed [31:0] oy,
                               logic [31:0] cyc);
      step_result_type r;
      longint tx, ty, dx, dy, v;
      logic [31:0] dt, t, damp, g;
      logic [32:0] acc;
      logic [63:0] tw;
      r = '0;
      if (m_settled) begin
         if (cyc != m_seen_cycle) m_settled = 1'b0;
      end else begin
         tx = clamp32(longint'(sx) - longint'(ox));
         ty = clamp32(longint'(sy) - longint'(oy));
         dt = (now > m_last_time) ? now - m_last_time : 32'd0;
         m_last_time = now;
         if (dt != 0) begin
            dx = clamp32(tx - m_pos_x);
            dy = clamp32(ty - m_pos_y);
            if (abs64(dx) < m_threshold && abs64(m_vel_x) < m_threshold) begin
               acc = {1'b0, m_still_timer} + dt;
               m_still_timer = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
               if (m_still_timer > m_settle) begin
                  m_still_timer = 0;
                  m_settled = 1'b1;
                  m_seen_cycle = cyc;
                  r.became_stable = 1'b1;
               end
            end else begin
               m_still_timer = 0;
            end
            if (!m_settled) begin
               tw = 64'(dt) * 64'(m_tscale);
               t = (tw > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tw[31:0];
               damp = friction_power(32'(m_friction), t);
               tw = (64'(m_gain) * 64'(t)) >> 16;
               g = tw[31:0];
               v = clamp32(scale_signed(m_vel_x, damp) + scale_signed(dx, g));
               m_vel_x = v;
               m_pos_x = clamp32(m_pos_x + v);
               v = clamp32(scale_signed(m_vel_y, damp) + scale_signed(dy, g));
               m_vel_y = v;
               m_pos_y = clamp32(m_pos_y + v);
            end else begin
               m_pos_x = tx;
               m_pos_y = ty;
            end
         end
         r.dir_x = 32'(clamp32(tx - m_pos_x));
         r.dir_y = 32'(clamp32(ty - m_pos_y));
         r.dir_valid = 1'b1;
      end
      r.is_stable = m_settled;
      expected_q.push_back(r);
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      error_count++;
   endtask

   task automatic write_reg(logic [2:0] idx, logic [21:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_FRICTION:  m_friction = val[15:0];
         CSR_GAIN:      m_gain = val[15:0];
         CSR_TSCALE:    m_tscale = val[7:0];
         CSR_THRESHOLD: m_threshold = val[15:0];
         CSR_SETTLE:    m_settle = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // send one item; predictor runs at acceptance
   task automatic send_step(logic [31:0] now, logic signed [31:0] sx, logic signed [31:0] sy,
                            logic signed [31:0] ox, logic signed [31:0] oy,
                            logic [31:0] cyc);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_time_now <= now;
      req_scroll_x <= sx;
      req_scroll_y <= sy;
      req_overshoot_x <= ox;
      req_overshoot_y <= oy;
      req_cycle_id <= cyc;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_step(now, sx, sy, ox, oy, cyc);
   endtask

   // advance time by dt and step toward the scroll position less the overshoot
   task automatic frame(logic [31:0] dt, logic signed [31:0] sx, logic signed [31:0] sy,
                        logic signed [31:0] ox, logic signed [31:0] oy);
      clock_now += dt;
      send_step(clock_now, sx, sy, ox, oy, cur_cycle);
   endtask

   function automatic logic signed [31:0] rand_pos();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed(32'($urandom_range(2000))) - 1000;
         default: return $signed(32'($urandom_range(40 << 16))) - (20 << 16);
      endcase
   endfunction

   task automatic test_directed();
      clock_now = 0;
      cur_cycle = 0;
      send_step(32'd100, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'd0);  // at rest, same id
      cur_cycle = 32'hFFFF_FFFF;
      send_step(32'd200, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, cur_cycle);
      send_step(32'd100, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, cur_cycle);
      send_step(32'd100, 32'sh10000, 32'sh0, 32'sh0, 32'sh0, cur_cycle);  // time stuck
      send_step(32'h0010_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
                cur_cycle);
      send_step(32'hFFFF_FFFF, 32'sh10000, -32'sh10000, 32'sh0, 32'sh0, cur_cycle);
      send_step(32'hFFFF_FFFF, 32'sh0, 32'sh0, 32'sh0, 32'sh0, cur_cycle);
      clock_now = 32'hFFFF_FFFF;
   endtask

   // settle toward fixed targets, then wake with a new cycle id
   task automatic test_chase(int n_items);
      logic signed [31:0] tx, ty;
      int left;
      left = n_items;
      while (left > 0) begin
         if (clock_now > 32'hF000_0000) clock_now = 0;
         cur_cycle = $urandom;
         tx = rand_pos();
         ty = rand_pos();
         for (int k = $urandom_range(3, 40); k > 0 && left > 0; k--) begin
            if ($urandom_range(9) == 0)
               send_step($urandom, $urandom, $urandom, $urandom, $urandom,
                         ($urandom_range(1) ? cur_cycle : $urandom));
            else
               frame(($urandom_range(7) == 0) ? 32'($urandom_range(0, 3 << 16))
                                              : 32'($urandom_range(1, 2200)),
                     tx, ty, $signed(32'($urandom_range(600))) - 300, 32'sd0);
            left--;
         end
      end
   endtask

   task automatic test_settings();
      write_reg(CSR_FRICTION, 22'd0);
      write_reg(CSR_GAIN, 22'd65535);
      write_reg(CSR_TSCALE, 22'd255);
      write_reg(CSR_THRESHOLD, 22'd65535);
      write_reg(CSR_SETTLE, 22'd0);
      write_reg(CSR_UNUSED, 22'h3FFFFF);
      test_chase(120);
      wait_drained();
      write_reg(CSR_FRICTION, 22'd65535);
      write_reg(CSR_GAIN, 22'd0);
      write_reg(CSR_TSCALE, 22'd1);
      write_reg(CSR_THRESHOLD, 22'd0);
      write_reg(CSR_SETTLE, 22'h3FFFFF);
      test_chase(60);
      wait_drained();
      for (int p = 0; p < 3; p++) begin
         write_reg(CSR_FRICTION, 22'($urandom));
         write_reg(CSR_GAIN, 22'($urandom));
         write_reg(CSR_TSCALE, 22'($urandom_range(1, 255)));
         write_reg(CSR_THRESHOLD, 22'($urandom_range(20, 9000)));
         write_reg(CSR_SETTLE, 22'($urandom_range(0, 40000)));
         test_chase(90);
         wait_drained();
      end
      write_reg(CSR_TSCALE, 22'd0);
      test_chase(30);
      wait_drained();
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3_000_000) begin
         $display("damped_spring_chaser test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      step_result_type w;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected item", 0, 0);
            end else begin
               w = expected_q.pop_front();
               if (rsp_dir_x !== w.dir_x) report_mismatch("dir_x", rsp_dir_x, w.dir_x);
               if (rsp_dir_y !== w.dir_y) report_mismatch("dir_y", rsp_dir_y, w.dir_y);
               if (rsp_dir_valid !== w.dir_valid)
                  report_mismatch("dir_valid", rsp_dir_valid, w.dir_valid);
               if (rsp_is_stable !== w.is_stable)
                  report_mismatch("is_stable", rsp_is_stable, w.is_stable);
               if (rsp_became_stable !== w.became_stable)
                  report_mismatch("became_stable", rsp_became_stable, w.became_stable);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      reset_predictor();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 17;
      recv_idle_pct = 47;
      test_directed();
      test_chase(120);
      wait_drained();
      send_idle_pct = 47;
      recv_idle_pct = 17;
      test_settings();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_chase(80);
      wait_drained();
      if (error_count == 0) begin
         $display("damped_spring_chaser test passed");
      end else begin
         $display("damped_spring_chaser test failed");
      end
      $finish;
   end
endmodule
